@@ src/ttok_pkg.sv @@
// Shared types and constants of the text tokenizer.
// No dependencies; imported by every other file in src.
`default_nettype none

package ttok_pkg;

    localparam int TOKEN_CHARS_DEF = 128;   // token store size in bytes, multiple of 8
    localparam int MAX_LIMIT       = 128;   // token_limit saturates here
    localparam int LEN_W           = 8;     // token length, 0..128
    localparam int QUEUE_DEPTH     = 2;     // command queue between front and back
    localparam int CFG_DATA_W      = 64;
    localparam int REG_ADDR_W      = 6;     // five 64-bit registers at 8-byte spacing
    localparam int CHUNK_BYTES     = 8;

    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_SLASH = 8'h2f;
    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_NL    = 8'h0a;

    localparam logic [63:0] SEP_MASK0_RST = 64'h0000_0001_0000_2600;
    localparam logic [7:0]  LIMIT_RST     = 8'd128;

    typedef enum logic [2:0] {
        REG_SEP_MASK_0 = 3'd0,
        REG_SEP_MASK_1 = 3'd1,
        REG_SEP_MASK_2 = 3'd2,
        REG_SEP_MASK_3 = 3'd3,
        REG_TOKEN_LIMIT = 3'd4
    } reg_idx_t;

    typedef enum logic [1:0] {
        OUT_WORD    = 2'd0,
        OUT_QUOTE   = 2'd1,
        OUT_DISCARD = 2'd2,
        OUT_END     = 2'd3
    } outcome_t;

    typedef struct packed {
        logic [255:0] sep_mask;
        logic [7:0]   limit;
    } cfg_t;

    // One finished token for the back end; end_after appends an end-of-text marker.
    typedef struct packed {
        logic [LEN_W-1:0] len;
        outcome_t         outcome;
        logic             end_after;
    } cmd_t;

    typedef struct packed {
        logic             en;
        logic [LEN_W-1:0] idx;
        logic [7:0]       data;
    } wr_t;

    typedef struct packed {
        logic store_done;   // last chunk of a stored token has been read out
    } back_status_t;

endpackage

`default_nettype wire

@@ src/ttok_regs.sv @@
// APB-style configuration registers: separator mask and token limit.
// Depends on ttok_pkg.
`default_nettype none

module ttok_regs (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             psel,
    input  wire logic                             penable,
    input  wire logic                             pwrite,
    input  wire logic [ttok_pkg::REG_ADDR_W-1:0]  paddr,
    input  wire logic [ttok_pkg::CFG_DATA_W-1:0]  pwdata,
    output logic      [ttok_pkg::CFG_DATA_W-1:0]  prdata,
    output logic                                  pready,
    output ttok_pkg::cfg_t                        cfg
);
    import ttok_pkg::*;

    logic [63:0] sep0_reg, sep1_reg, sep2_reg, sep3_reg;
    logic [7:0]  limit_reg;
    reg_idx_t    idx;
    logic        wr_en;

    assign pready = 1'b1;
    assign idx    = reg_idx_t'(paddr[REG_ADDR_W-1:3]);
    assign wr_en  = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sep0_reg  <= SEP_MASK0_RST;
            sep1_reg  <= '0;
            sep2_reg  <= '0;
            sep3_reg  <= '0;
            limit_reg <= LIMIT_RST;
        end
        else if (wr_en)
        begin
            unique case (idx)
                REG_SEP_MASK_0:  sep0_reg  <= pwdata;
                REG_SEP_MASK_1:  sep1_reg  <= pwdata;
                REG_SEP_MASK_2:  sep2_reg  <= pwdata;
                REG_SEP_MASK_3:  sep3_reg  <= pwdata;
                REG_TOKEN_LIMIT: limit_reg <= pwdata[7:0];
                default:         ;
            endcase
        end
    end

    always_comb
    begin
        unique case (idx)
            REG_SEP_MASK_0:  prdata = sep0_reg;
            REG_SEP_MASK_1:  prdata = sep1_reg;
            REG_SEP_MASK_2:  prdata = sep2_reg;
            REG_SEP_MASK_3:  prdata = sep3_reg;
            REG_TOKEN_LIMIT: prdata = {{(CFG_DATA_W-8){1'b0}}, limit_reg};
            default:         prdata = '0;
        endcase
    end

    assign cfg.sep_mask = {sep3_reg, sep2_reg, sep1_reg, sep0_reg};
    assign cfg.limit    = limit_reg;

endmodule

`default_nettype wire

@@ src/ttok_queue.sv @@
// Short command queue between the parser front end and the chunk back end.
// Depends on ttok_pkg. DEPTH must be a power of two.
`default_nettype none

module ttok_queue #(
    parameter int DEPTH = ttok_pkg::QUEUE_DEPTH
) (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           push,
    input  ttok_pkg::cmd_t      push_cmd,
    output logic                full,
    input  wire logic           pop,
    output logic                valid,
    output ttok_pkg::cmd_t      pop_cmd
);
    import ttok_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    cmd_t             entry_reg [DEPTH];
    logic [PTR_W-1:0] wptr_reg, rptr_reg;
    logic [CNT_W-1:0] count_reg;

    assign full    = (count_reg == CNT_W'(DEPTH));
    assign valid   = (count_reg != '0);
    assign pop_cmd = entry_reg[rptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wptr_reg] <= push_cmd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            if (push)
            begin
                wptr_reg <= wptr_reg + 1'b1;
            end
            if (pop)
            begin
                rptr_reg <= rptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

@@ src/ttok_front.sv @@
// Parser front end: classifies each text byte, writes token bytes, queues finished tokens.
// Depends on ttok_pkg; feeds ttok_queue and the token store in ttok_back.
`default_nettype none

module ttok_front #(
    parameter int TOKEN_CHARS = ttok_pkg::TOKEN_CHARS_DEF
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  ttok_pkg::cfg_t            cfg,
    input  wire logic                 text_valid,
    output logic                      text_ready,
    input  wire logic [7:0]           text_byte,
    output logic                      q_push,
    output ttok_pkg::cmd_t            q_cmd,
    input  wire logic                 q_full,
    output ttok_pkg::wr_t             wr,
    input  ttok_pkg::back_status_t    bstat
);
    import ttok_pkg::*;

    localparam int MAX_LIM_INT = (TOKEN_CHARS < MAX_LIMIT) ? TOKEN_CHARS : MAX_LIMIT;
    localparam logic [LEN_W-1:0] MAX_LIM = LEN_W'(MAX_LIM_INT);

    typedef enum logic [2:0] {
        M_SKIP,
        M_SLASH,
        M_COMMENT,
        M_QUOTE,
        M_WORD
    } mode_t;

    mode_t            mode_reg, mode_next;
    logic [LEN_W-1:0] len_reg, len_next;
    logic             hold_reg, hold_next;   // a stored token is being read out

    logic             accept;
    logic             b_sep;
    logic [LEN_W-1:0] lim;
    logic [LEN_W-1:0] cur_len;
    logic [LEN_W-1:0] quote_cap;
    logic             push;
    cmd_t             cmd;

    mode_t            sk_mode;
    logic [LEN_W-1:0] sk_len;
    wr_t              sk_wr;
    logic             sk_end;

    assign text_ready = !q_full && !hold_reg;
    assign accept     = text_valid && text_ready;
    assign b_sep      = (text_byte == CH_NUL) || cfg.sep_mask[text_byte];

    always_comb
    begin
        if (cfg.limit == '0)
        begin
            lim = LEN_W'(1);
        end
        else if (cfg.limit > MAX_LIM)
        begin
            lim = MAX_LIM;
        end
        else
        begin
            lim = cfg.limit;
        end
    end

    assign quote_cap = lim - 1'b1;
    // after a lone slash the '/' already sits in entry 0
    assign cur_len   = (mode_reg == M_SLASH) ? LEN_W'(1) : len_reg;

    // byte as seen while skipping separators
    always_comb
    begin
        sk_mode = M_SKIP;
        sk_len  = len_reg;
        sk_wr   = '0;
        sk_end  = 1'b0;
        if (text_byte == CH_NUL)
        begin
            sk_end = 1'b1;
            sk_len = '0;
        end
        else if (!b_sep)
        begin
            sk_len = '0;
            if (text_byte == CH_SLASH)
            begin
                sk_mode    = M_SLASH;
                sk_wr.en   = 1'b1;
                sk_wr.data = CH_SLASH;
            end
            else if (text_byte == CH_QUOTE)
            begin
                sk_mode = M_QUOTE;
            end
            else
            begin
                sk_mode    = M_WORD;
                sk_wr.en   = 1'b1;
                sk_wr.data = text_byte;
                sk_len     = LEN_W'(1);
            end
        end
    end

    always_comb
    begin
        mode_next = mode_reg;
        len_next  = len_reg;
        wr        = '0;
        push      = 1'b0;
        cmd       = '0;
        if (accept)
        begin
            unique case (mode_reg)
                M_SLASH, M_WORD:
                begin
                    if (mode_reg == M_SLASH && text_byte == CH_SLASH)
                    begin
                        mode_next = M_COMMENT;
                    end
                    else if (!b_sep)
                    begin
                        mode_next = M_WORD;
                        len_next  = cur_len;
                        if (cur_len < lim)
                        begin
                            wr.en    = 1'b1;
                            wr.idx   = cur_len;
                            wr.data  = text_byte;
                            len_next = cur_len + 1'b1;
                        end
                    end
                    else
                    begin
                        push          = 1'b1;
                        cmd.end_after = (text_byte == CH_NUL);
                        if (cur_len >= lim)
                        begin
                            cmd.outcome = OUT_DISCARD;
                        end
                        else
                        begin
                            cmd.len     = cur_len;
                            cmd.outcome = OUT_WORD;
                        end
                        len_next  = '0;
                        mode_next = M_SKIP;
                    end
                end
                M_COMMENT:
                begin
                    if (text_byte == CH_NUL || text_byte == CH_NL)
                    begin
                        mode_next = sk_mode;
                        len_next  = sk_len;
                        wr        = sk_wr;
                        push      = sk_end;
                        cmd.outcome = OUT_END;
                    end
                end
                M_QUOTE:
                begin
                    if (text_byte == CH_QUOTE || text_byte == CH_NUL)
                    begin
                        push          = 1'b1;
                        cmd.len       = (len_reg > quote_cap) ? quote_cap : len_reg;
                        cmd.outcome   = OUT_QUOTE;
                        cmd.end_after = (text_byte == CH_NUL);
                        len_next      = '0;
                        mode_next     = M_SKIP;
                    end
                    else if (len_reg < lim)
                    begin
                        wr.en    = 1'b1;
                        wr.idx   = len_reg;
                        wr.data  = text_byte;
                        len_next = len_reg + 1'b1;
                    end
                end
                default:
                begin
                    mode_next   = sk_mode;
                    len_next    = sk_len;
                    wr          = sk_wr;
                    push        = sk_end;
                    cmd.outcome = OUT_END;
                end
            endcase
        end
    end

    assign q_push = push;
    assign q_cmd  = cmd;

    always_comb
    begin
        hold_next = hold_reg;
        if (bstat.store_done)
        begin
            hold_next = 1'b0;
        end
        if (push && cmd.len != '0)
        begin
            hold_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= M_SKIP;
            len_reg  <= '0;
            hold_reg <= 1'b0;
        end
        else
        begin
            mode_reg <= mode_next;
            len_reg  <= len_next;
            hold_reg <= hold_next;
        end
    end

endmodule

`default_nettype wire

@@ src/ttok_back.sv @@
// Back end: token store and chunk sequencer with the output register.
// Depends on ttok_pkg; takes commands from ttok_queue and store writes from ttok_front.
`default_nettype none

module ttok_back #(
    parameter int TOKEN_CHARS = ttok_pkg::TOKEN_CHARS_DEF
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  ttok_pkg::wr_t             wr,
    input  wire logic                 q_valid,
    input  ttok_pkg::cmd_t            q_cmd,
    output logic                      q_pop,
    output ttok_pkg::back_status_t    bstat,
    output logic                      tok_valid,
    input  wire logic                 tok_ready,
    output logic [63:0]               token_bytes,
    output logic [3:0]                byte_count,
    output logic                      last,
    output logic [1:0]                outcome
);
    import ttok_pkg::*;

    localparam int ROWS  = TOKEN_CHARS / CHUNK_BYTES;
    localparam int ROW_W = (ROWS > 1) ? $clog2(ROWS) : 1;

    typedef enum logic [1:0] {
        B_IDLE,
        B_READ,
        B_SEND,
        B_END
    } state_t;

    // one row holds eight bytes, byte 0 in the low lane
    logic [63:0]      mem [ROWS];
    logic [63:0]      rdata_reg;
    logic             rd_en;
    logic [ROW_W-1:0] rd_row;
    logic [ROW_W-1:0] wr_row;

    state_t           state_reg;
    logic [LEN_W-1:0] len_reg;
    logic [LEN_W-1:0] pos_reg;
    outcome_t         oc_reg;
    logic             end_after_reg;

    logic             out_valid_reg;
    logic [63:0]      out_bytes_reg;
    logic [3:0]       out_count_reg;
    logic             out_last_reg;
    outcome_t         out_outcome_reg;

    logic [LEN_W-1:0] rem;
    logic [3:0]       cnt;
    logic             last_chunk;
    logic             out_free;
    logic             out_load;
    logic [63:0]      masked;

    assign wr_row = ROW_W'(wr.idx >> 3);
    assign rd_row = ROW_W'(pos_reg >> 3);
    assign rd_en  = (state_reg == B_READ);

    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem[wr_row][wr.idx[2:0]*8 +: 8] <= wr.data;
        end
        if (rd_en)
        begin
            rdata_reg <= mem[rd_row];
        end
    end

    assign rem        = len_reg - pos_reg;
    assign last_chunk = (rem <= LEN_W'(CHUNK_BYTES));
    assign cnt        = last_chunk ? rem[3:0] : 4'(CHUNK_BYTES);
    assign out_free   = !out_valid_reg || tok_ready;
    assign out_load   = out_free && ((state_reg == B_SEND) || (state_reg == B_END));

    always_comb
    begin
        for (int i = 0; i < CHUNK_BYTES; i++)
        begin
            masked[i*8 +: 8] = (4'(i) < cnt) ? rdata_reg[i*8 +: 8] : 8'h00;
        end
    end

    assign q_pop = (state_reg == B_IDLE) && q_valid;
    assign bstat.store_done = (state_reg == B_SEND) && out_free && last_chunk
                              && (len_reg != '0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= B_IDLE;
            len_reg         <= '0;
            pos_reg         <= '0;
            oc_reg          <= OUT_WORD;
            end_after_reg   <= 1'b0;
            out_valid_reg   <= 1'b0;
            out_bytes_reg   <= '0;
            out_count_reg   <= '0;
            out_last_reg    <= 1'b0;
            out_outcome_reg <= OUT_WORD;
        end
        else
        begin
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (tok_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                B_IDLE:
                begin
                    if (q_valid)
                    begin
                        len_reg       <= q_cmd.len;
                        pos_reg       <= '0;
                        oc_reg        <= q_cmd.outcome;
                        end_after_reg <= q_cmd.end_after;
                        state_reg     <= B_READ;
                    end
                end
                B_READ:
                begin
                    state_reg <= B_SEND;
                end
                B_SEND:
                begin
                    if (out_free)
                    begin
                        out_bytes_reg   <= masked;
                        out_count_reg   <= cnt;
                        out_last_reg    <= last_chunk;
                        out_outcome_reg <= oc_reg;
                        pos_reg         <= pos_reg + LEN_W'(cnt);
                        if (!last_chunk)
                        begin
                            state_reg <= B_READ;
                        end
                        else if (end_after_reg)
                        begin
                            state_reg <= B_END;
                        end
                        else
                        begin
                            state_reg <= B_IDLE;
                        end
                    end
                end
                B_END:
                begin
                    if (out_free)
                    begin
                        out_bytes_reg   <= '0;
                        out_count_reg   <= '0;
                        out_last_reg    <= 1'b1;
                        out_outcome_reg <= OUT_END;
                        state_reg       <= B_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= B_IDLE;
                end
            endcase
        end
    end

    assign tok_valid   = out_valid_reg;
    assign token_bytes = out_bytes_reg;
    assign byte_count  = out_count_reg;
    assign last        = out_last_reg;
    assign outcome     = out_outcome_reg;

endmodule

`default_nettype wire

@@ src/text_tokenizer_top.sv @@
// Top level of the text tokenizer: configuration registers, parser front end,
// command queue and chunk back end. Depends on ttok_pkg and all other src modules.
`default_nettype none

// Text goes in one byte per request and tokens come out as chunks of up to eight
// bytes, last chunk flagged, outcome telling word, quoted string, discarded word
// or end of text. Separators, comments and bytes inside a token are taken one per
// cycle while the command queue is not full. Once a token with stored bytes is
// closed, the next byte waits until the back end has read that token out of the
// store, each chunk taking a store row read and then an output register load; the
// wait grows while the back end is still busy with earlier empty tokens or the
// output side stalls. Empty tokens and end markers queue without holding input.
// Configuration sits on a 64-bit APB-style port, one register every 8 bytes;
// write it only while idle. TOKEN_CHARS must be a multiple of 8.
module text_tokenizer_top #(
    parameter int TOKEN_CHARS = ttok_pkg::TOKEN_CHARS_DEF
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             psel,
    input  wire logic                             penable,
    input  wire logic                             pwrite,
    input  wire logic [ttok_pkg::REG_ADDR_W-1:0]  paddr,
    input  wire logic [ttok_pkg::CFG_DATA_W-1:0]  pwdata,
    output logic      [ttok_pkg::CFG_DATA_W-1:0]  prdata,
    output logic                                  pready,
    input  wire logic                             text_valid,
    output logic                                  text_ready,
    input  wire logic [7:0]                       text_byte,
    output logic                                  tok_valid,
    input  wire logic                             tok_ready,
    output logic [63:0]                           token_bytes,
    output logic [3:0]                            byte_count,
    output logic                                  last,
    output logic [1:0]                            outcome
);
    import ttok_pkg::*;

    cfg_t         cfg;
    logic         q_push;
    cmd_t         q_push_cmd;
    logic         q_full;
    logic         q_pop;
    logic         q_valid;
    cmd_t         q_pop_cmd;
    wr_t          wr;
    back_status_t bstat;

    ttok_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    ttok_front #(
        .TOKEN_CHARS (TOKEN_CHARS)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg),
        .text_valid (text_valid),
        .text_ready (text_ready),
        .text_byte  (text_byte),
        .q_push     (q_push),
        .q_cmd      (q_push_cmd),
        .q_full     (q_full),
        .wr         (wr),
        .bstat      (bstat)
    );

    ttok_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_push),
        .push_cmd (q_push_cmd),
        .full     (q_full),
        .pop      (q_pop),
        .valid    (q_valid),
        .pop_cmd  (q_pop_cmd)
    );

    ttok_back #(
        .TOKEN_CHARS (TOKEN_CHARS)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .wr          (wr),
        .q_valid     (q_valid),
        .q_cmd       (q_pop_cmd),
        .q_pop       (q_pop),
        .bstat       (bstat),
        .tok_valid   (tok_valid),
        .tok_ready   (tok_ready),
        .token_bytes (token_bytes),
        .byte_count  (byte_count),
        .last        (last),
        .outcome     (outcome)
    );

    // the queue must never be pushed while full
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        q_push |-> !q_full)
        else $error("command queue overflow");

    // input is held while the back end still reads the token store
    a_store_hold: assert property (@(posedge clk) disable iff (!rst_n)
        bstat.store_done |-> !text_ready && !wr.en)
        else $error("token store written while being read out");

    // every chunk but the last of a token is full
    a_full_chunks: assert property (@(posedge clk) disable iff (!rst_n)
        tok_valid && !last |-> byte_count == 4'(CHUNK_BYTES))
        else $error("short chunk before end of token");

    // the end marker is a single empty chunk
    a_end_marker: assert property (@(posedge clk) disable iff (!rst_n)
        tok_valid && outcome == OUT_END |-> last && byte_count == '0 && token_bytes == '0)
        else $error("malformed end-of-text marker");

endmodule

`default_nettype wire
